/* rtl/core/vmcrc_pkg.sv */
// ----------------------------------------------------------------------------
// vmcrc_pkg
// Shared widths and word types for the von Mises cell removal check.
// ----------------------------------------------------------------------------
package vmcrc_pkg;

    localparam int ID_W                = 24;
    localparam int GRAD_W              = 24;
    localparam int MOD_W               = 31;
    localparam int CRIT_W              = 36;
    localparam int GRAD_FRAC_BITS_DEF  = 20;

    // one cell per input word, gradient row-major
    typedef struct packed {
        logic        [ID_W-1:0]   cell_index;
        logic signed [GRAD_W-1:0] grad_xx;
        logic signed [GRAD_W-1:0] grad_xy;
        logic signed [GRAD_W-1:0] grad_xz;
        logic signed [GRAD_W-1:0] grad_yx;
        logic signed [GRAD_W-1:0] grad_yy;
        logic signed [GRAD_W-1:0] grad_yz;
        logic signed [GRAD_W-1:0] grad_zx;
        logic signed [GRAD_W-1:0] grad_zy;
        logic signed [GRAD_W-1:0] grad_zz;
        logic        [MOD_W-1:0]  shear_modulus;
        logic        [MOD_W-1:0]  lame_lambda;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0] cell_out;
        logic            remove;
    } t_result;

endpackage

/* rtl/core/von_mises_cell_removal_check.sv */
// ----------------------------------------------------------------------------
// von_mises_cell_removal_check
// Flags a mesh cell whose von Mises equivalent stress exceeds a set limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_item and raise start; the word is taken at every
//   rising edge with start high and busy low. busy is always low, so one
//   cell can be taken in every cycle.
//   Output channel: o_strobe is high for one cycle with o_result, once the
//   input word has passed through every pipeline stage (throughput one word per
//   cycle). The pipeline has six register stages: deviator, squares, sum,
//   partial products of mu^2*sum, product assembly, compare. The receiver
//   cannot stall; every result must be taken in its strobe cycle.
//   Configuration: i_cfg_we writes i_cfg_wdata into the critical stress
//   register. Write only with no cell in flight. The limit reaches the
//   compare through a three-stage squaring chain, shorter than the path of
//   any cell taken after the write.
//   Reset: synchronous, active low; clears the stage valid bits and sets the
//   critical stress to zero. No result is produced for words in flight.
//   The test is mu^2 * sum(D^2) > 6 * crit^2 * 2^(2*GRAD_FRAC_BITS) with
//   D = 3*(G+G^T) - 2*tr(G)*I, exact; lame_lambda drops out of the deviator.
// ----------------------------------------------------------------------------
module von_mises_cell_removal_check #(
    parameter int GRAD_FRAC_BITS = vmcrc_pkg::GRAD_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  vmcrc_pkg::t_item                i_item,
    output logic                            o_strobe,
    output vmcrc_pkg::t_result              o_result,
    input  logic                            i_cfg_we,
    input  logic [vmcrc_pkg::CRIT_W-1:0]    i_cfg_wdata
);
    import vmcrc_pkg::*;

    localparam int D_W    = GRAD_W + 4;          // deviator entry, signed
    localparam int P_W    = 2 * D_W;             // signed square
    localparam int Q_W    = 2 * D_W - 3;         // magnitude of a square
    localparam int S_W    = Q_W + 3;             // sum of nine squares
    localparam int MU2_W  = 2 * MOD_W;
    localparam int MLO_W  = MU2_W / 2;
    localparam int MHI_W  = MU2_W - MLO_W;
    localparam int SLO_W  = S_W / 2;
    localparam int SHI_W  = S_W - SLO_W;
    localparam int PP_W   = MLO_W + SLO_W > MHI_W + SHI_W ? MLO_W + SLO_W : MHI_W + SHI_W;
    localparam int L_W    = MU2_W + S_W;
    localparam int CH_W   = CRIT_W / 2;
    localparam int CL_W   = CRIT_W - CH_W;
    localparam int HP_W   = 2 * (CH_W > CL_W ? CH_W : CL_W);
    localparam int SQ_W   = 2 * CRIT_W;
    localparam int THR_W  = SQ_W + 3 + 2 * GRAD_FRAC_BITS;
    localparam int CMP_W  = THR_W > L_W ? THR_W : L_W;
    localparam int NSTG   = 6;

    // ---------------- control ----------------
    logic              w_take;
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   n_vld;
    logic [CRIT_W-1:0] r_crit;

    assign busy   = 1'b0;
    assign w_take = start && !busy;
    assign n_vld  = {r_vld[NSTG-2:0], w_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_crit <= '0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_crit <= i_cfg_wdata;
            end
        end
    end

    // ---------------- stage 1: deviator ----------------
    logic signed [D_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz;
    logic signed [D_W-1:0] n_dxx, n_dyy, n_dzz, n_dxy, n_dxz, n_dyz;
    logic signed [D_W-1:0] r_dxx, r_dyy, r_dzz, r_dxy, r_dxz, r_dyz;
    logic [MOD_W-1:0]      r_mu1;
    logic [ID_W-1:0]       r_id1, r_id2, r_id3, r_id4, r_id5;

    always_comb begin
        e_xx = D_W'(i_item.grad_xx);
        e_yy = D_W'(i_item.grad_yy);
        e_zz = D_W'(i_item.grad_zz);
        // symmetric part, doubled
        e_xy = D_W'(i_item.grad_xy) + D_W'(i_item.grad_yx);
        e_xz = D_W'(i_item.grad_xz) + D_W'(i_item.grad_zx);
        e_yz = D_W'(i_item.grad_yz) + D_W'(i_item.grad_zy);
        // 6*g_ii - 2*tr = 4*g_ii - 2*(other two diagonals)
        n_dxx = (e_xx <<< 2) - (e_yy <<< 1) - (e_zz <<< 1);
        n_dyy = (e_yy <<< 2) - (e_xx <<< 1) - (e_zz <<< 1);
        n_dzz = (e_zz <<< 2) - (e_xx <<< 1) - (e_yy <<< 1);
        n_dxy = (e_xy <<< 1) + e_xy;
        n_dxz = (e_xz <<< 1) + e_xz;
        n_dyz = (e_yz <<< 1) + e_yz;
    end

    // ---------------- stage 2: squares and mu^2 ----------------
    logic signed [P_W-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
    logic [Q_W-1:0]        r_qxx, r_qyy, r_qzz, r_qxy, r_qxz, r_qyz;
    logic [MU2_W-1:0]      r_mu2_2, r_mu2_3;

    assign p_xx = r_dxx * r_dxx;
    assign p_yy = r_dyy * r_dyy;
    assign p_zz = r_dzz * r_dzz;
    assign p_xy = r_dxy * r_dxy;
    assign p_xz = r_dxz * r_dxz;
    assign p_yz = r_dyz * r_dyz;

    // ---------------- stage 3: sum of nine squares ----------------
    logic [S_W-1:0] n_sum;
    logic [S_W-1:0] r_sum;

    // off-diagonal entries appear twice
    assign n_sum = S_W'(r_qxx) + S_W'(r_qyy) + S_W'(r_qzz)
                 + (S_W'(r_qxy) << 1) + (S_W'(r_qxz) << 1) + (S_W'(r_qyz) << 1);

    // ---------------- stage 4: partial products ----------------
    logic [PP_W-1:0] r_pll, r_plh, r_phl, r_phh;

    // ---------------- stage 5: product assembly ----------------
    logic [L_W-1:0] n_lhs;
    logic [L_W-1:0] r_lhs;

    assign n_lhs = L_W'(r_pll)
                 + (L_W'(r_plh) << SLO_W)
                 + (L_W'(r_phl) << MLO_W)
                 + (L_W'(r_phh) << (MLO_W + SLO_W));

    // ---------------- limit squaring chain ----------------
    logic [CH_W-1:0]  w_ch;
    logic [CL_W-1:0]  w_cl;
    logic [HP_W-1:0]  r_thh, r_thl, r_tll;
    logic [SQ_W-1:0]  r_tsq;
    logic [THR_W-1:0] r_thr;

    assign w_ch = r_crit[CRIT_W-1:CL_W];
    assign w_cl = r_crit[CL_W-1:0];

    // ---------------- stage 6: compare ----------------
    logic    n_remove;
    t_result r_res;

    assign n_remove = CMP_W'(r_lhs) > CMP_W'(r_thr);

    always_ff @(posedge i_clk) begin
        // stage 1
        r_dxx <= n_dxx;
        r_dyy <= n_dyy;
        r_dzz <= n_dzz;
        r_dxy <= n_dxy;
        r_dxz <= n_dxz;
        r_dyz <= n_dyz;
        r_mu1 <= i_item.shear_modulus;
        r_id1 <= i_item.cell_index;
        // stage 2
        r_qxx   <= p_xx[Q_W-1:0];
        r_qyy   <= p_yy[Q_W-1:0];
        r_qzz   <= p_zz[Q_W-1:0];
        r_qxy   <= p_xy[Q_W-1:0];
        r_qxz   <= p_xz[Q_W-1:0];
        r_qyz   <= p_yz[Q_W-1:0];
        r_mu2_2 <= MU2_W'(r_mu1) * MU2_W'(r_mu1);
        r_id2   <= r_id1;
        // stage 3
        r_sum   <= n_sum;
        r_mu2_3 <= r_mu2_2;
        r_id3   <= r_id2;
        // stage 4
        r_pll <= PP_W'(r_mu2_3[MLO_W-1:0])     * PP_W'(r_sum[SLO_W-1:0]);
        r_plh <= PP_W'(r_mu2_3[MLO_W-1:0])     * PP_W'(r_sum[S_W-1:SLO_W]);
        r_phl <= PP_W'(r_mu2_3[MU2_W-1:MLO_W]) * PP_W'(r_sum[SLO_W-1:0]);
        r_phh <= PP_W'(r_mu2_3[MU2_W-1:MLO_W]) * PP_W'(r_sum[S_W-1:SLO_W]);
        r_id4 <= r_id3;
        // stage 5
        r_lhs <= n_lhs;
        r_id5 <= r_id4;
        // stage 6
        r_res.cell_out <= r_id5;
        r_res.remove   <= n_remove;
        // limit: crit^2 from halves, then times 6, then scaled to gradient units
        r_thh <= HP_W'(w_ch) * HP_W'(w_ch);
        r_thl <= HP_W'(w_ch) * HP_W'(w_cl);
        r_tll <= HP_W'(w_cl) * HP_W'(w_cl);
        r_tsq <= (SQ_W'(r_thh) << (2 * CL_W)) + (SQ_W'(r_thl) << (CL_W + 1)) + SQ_W'(r_tll);
        r_thr <= (THR_W'(r_tsq) << (2 * GRAD_FRAC_BITS + 2))
               + (THR_W'(r_tsq) << (2 * GRAD_FRAC_BITS + 1));
    end

    assign o_strobe = r_vld[NSTG-1];
    assign o_result = r_res;

    // ---------------- assertions ----------------
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##6 o_strobe)
        else $error("taken word gave no result after six cycles");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_take, 6))
        else $error("result without a matching input word");

    a_cell_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.cell_out == $past(i_item.cell_index, 6))
        else $error("cell index out of order");

    a_zero_mu : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ($past(i_item.shear_modulus, 6) == '0) |-> !o_result.remove)
        else $error("cell with zero shear modulus flagged");

endmodule

/* tb/vmcrc_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmcrc_tb_pkg
// Removal flag tracker: predicts each cell's flag and checks the returned words.
// ----------------------------------------------------------------------------
package vmcrc_tb_pkg;

    import vmcrc_pkg::*;

    class removal_tracker;

        logic [CRIT_W-1:0] critical_stress = '0;
        t_result           pending_flags[$];
        int                mismatches    = 0;
        int                cells_checked = 0;
        int                cells_flagged = 0;

        task report_mismatch(input string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // exact form: mu^2 * sum(D^2) > 6 * crit^2 * 2^(2*frac), D = 3(G+G^T) - 2tr(G)I
        function t_result predict_removal(input t_item c);
            longint signed g[9];
            longint signed tr;
            longint signed dv;
            logic [63:0]   sq_sum;
            logic [127:0]  lhs;
            logic [127:0]  rhs;
            t_result       r;
            g[0] = $signed(c.grad_xx);
            g[1] = $signed(c.grad_xy);
            g[2] = $signed(c.grad_xz);
            g[3] = $signed(c.grad_yx);
            g[4] = $signed(c.grad_yy);
            g[5] = $signed(c.grad_yz);
            g[6] = $signed(c.grad_zx);
            g[7] = $signed(c.grad_zy);
            g[8] = $signed(c.grad_zz);
            tr = g[0] + g[4] + g[8];
            sq_sum = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    dv = 3 * (g[i*3+j] + g[j*3+i]);
                    if (i == j) begin
                        dv = dv - 2 * tr;
                    end
                    sq_sum = sq_sum + 64'(dv * dv);
                end
            end
            lhs = 128'(c.shear_modulus) * 128'(c.shear_modulus) * 128'(sq_sum);
            rhs = (128'(critical_stress) * 128'(critical_stress) * 128'd6)
                  << (2 * GRAD_FRAC_BITS_DEF);
            r.cell_out = c.cell_index;
            r.remove   = (lhs > rhs);
            return r;
        endfunction

        function void note_cell(input t_item c);
            pending_flags.push_back(predict_removal(c));
        endfunction

        task check_flag(input t_result got);
            t_result want;
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("word for cell %0d with nothing pending",
                                          got.cell_out));
                return;
            end
            want = pending_flags.pop_front();
            cells_checked++;
            if (want.remove) begin
                cells_flagged++;
            end
            if (got.cell_out !== want.cell_out) begin
                report_mismatch($sformatf("cell_out %h, want %h", got.cell_out, want.cell_out));
            end
            if (got.remove !== want.remove) begin
                report_mismatch($sformatf("cell %0d remove %b, want %b",
                                          want.cell_out, got.remove, want.remove));
            end
        endtask

    endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams mesh cells through the von Mises removal check under several
// critical stress settings and compares every flag with a predicted one.
// ----------------------------------------------------------------------------
module testbench;

    import vmcrc_pkg::*;
    import vmcrc_tb_pkg::*;

    localparam int PIPE_LATENCY   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_CELLS    = 125;

    localparam logic signed [GRAD_W-1:0] G_ONE = 24'sd1048576;
    localparam logic signed [GRAD_W-1:0] G_MAX = 24'sd8388607;
    localparam logic signed [GRAD_W-1:0] G_MIN = -24'sd8388608;
    localparam logic [MOD_W-1:0]         MOD_MAX  = '1;
    localparam logic [CRIT_W-1:0]        CRIT_MAX = '1;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_item             i_item      = '0;
    logic              o_strobe;
    t_result           o_result;
    logic              i_cfg_we    = 1'b0;
    logic [CRIT_W-1:0] i_cfg_wdata = '0;

    removal_tracker trk = new();
    int             stall_cycles = 0;
    int             settings_used = 1;

    von_mises_cell_removal_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            trk.note_cell(i_item);
        end
        if (i_rst_n && o_strobe) begin
            trk.check_flag(o_result);
        end
        if (i_rst_n && ((start && !busy) || o_strobe)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        @(posedge i_clk);
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] rand_bits(input int unsigned max_w);
        int unsigned w;
        logic [63:0] v;
        w = $urandom_range(0, 1) ? max_w : $urandom_range(max_w, 0);
        v = {$urandom, $urandom};
        if (w < 64) begin
            v = v & ((64'd1 << w) - 64'd1);
        end
        return v;
    endfunction

    function automatic logic signed [GRAD_W-1:0] rand_grad();
        logic signed [GRAD_W-1:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = GRAD_W'($urandom);
        end else begin
            v = $signed(GRAD_W'(rand_bits(GRAD_W - 1)));
            if ($urandom_range(0, 1)) begin
                v = -v;
            end
        end
        return v;
    endfunction

    // start stays high across back-to-back words
    task automatic drive_cell(input t_item c);
        @(negedge i_clk);
        i_item <= c;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_grads(
        input logic [ID_W-1:0]          idx,
        input logic signed [GRAD_W-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz,
        input logic [MOD_W-1:0]         mu,
        input logic [MOD_W-1:0]         lam
    );
        t_item c;
        c.cell_index    = idx;
        c.grad_xx       = xx;
        c.grad_xy       = xy;
        c.grad_xz       = xz;
        c.grad_yx       = yx;
        c.grad_yy       = yy;
        c.grad_yz       = yz;
        c.grad_zx       = zx;
        c.grad_zy       = zy;
        c.grad_zz       = zz;
        c.shear_modulus = mu;
        c.lame_lambda   = lam;
        drive_cell(c);
    endtask

    // limit only changes with the pipeline drained
    task automatic write_critical_stress(input logic [CRIT_W-1:0] v);
        @(negedge i_clk);
        start <= 1'b0;
        while (trk.pending_flags.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        trk.critical_stress = v;
        settings_used++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= ~v;
    endtask

    initial begin : stimulus
        t_item c;
        int    sent;
        int    burst;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero limit from reset: any nonzero deviator with nonzero mu is flagged
        send_grads(24'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MOD_MAX, MOD_MAX);
        send_grads(24'd1, G_ONE, 0, 0, 0, 0, 0, 0, 0, 0, '0, MOD_MAX);
        send_grads(24'd2, G_ONE, 0, 0, 0, G_ONE, 0, 0, 0, G_ONE, MOD_MAX, '0);
        send_grads(24'd3, 0, 24'sd1, 0, 0, 0, 0, 0, 0, 0, 31'd1, '0);
        send_grads(24'hFFFFFF, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN,
                   MOD_MAX, '0);
        send_grads(24'd5, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX, G_MAX,
                   MOD_MAX, MOD_MAX);

        // uniaxial unit strain with mu 1000 sits exactly on a 2000 kPa limit
        write_critical_stress(36'd2000);
        send_grads(24'd6, G_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1000, '0);
        send_grads(24'd7, G_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1000, MOD_MAX);
        send_grads(24'd8, G_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1001, 31'd12345);
        send_grads(24'd9, 0, 0, 0, 0, G_ONE, 0, 0, 0, 0, 31'd1000, 31'd77);
        send_grads(24'd10, 0, 0, 0, 0, 0, 0, 0, 0, G_ONE, 31'd1000, MOD_MAX);

        write_critical_stress(36'd1999);
        send_grads(24'd11, G_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1000, '0);
        send_grads(24'd12, 0, 0, 0, 0, G_ONE, 0, 0, 0, 0, 31'd999, '0);

        write_critical_stress(CRIT_MAX);
        send_grads(24'd13, G_MIN, G_MAX, G_MIN, G_MAX, G_MIN, G_MAX, G_MIN, G_MAX, G_MIN,
                   MOD_MAX, MOD_MAX);
        send_grads(24'd14, G_MAX, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MIN, G_MAX,
                   MOD_MAX, '0);
        send_grads(24'd15, 0, G_MAX, 0, G_MIN, 0, 0, 0, 0, 0, MOD_MAX, MOD_MAX);
        send_grads(24'd16, G_MAX, G_MAX, 0, G_MAX, G_MIN, 0, 0, 0, G_MAX, MOD_MAX, 31'd1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_critical_stress(CRIT_W'(rand_bits(CRIT_W)));
            sent = 0;
            while (sent < PHASE_CELLS) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < PHASE_CELLS; k++) begin
                    c.cell_index    = ID_W'($urandom);
                    c.grad_xx       = rand_grad();
                    c.grad_xy       = rand_grad();
                    c.grad_xz       = rand_grad();
                    c.grad_yx       = rand_grad();
                    c.grad_yy       = rand_grad();
                    c.grad_yz       = rand_grad();
                    c.grad_zx       = rand_grad();
                    c.grad_zy       = rand_grad();
                    c.grad_zz       = rand_grad();
                    c.shear_modulus = MOD_W'(rand_bits(MOD_W));
                    c.lame_lambda   = MOD_W'($urandom);
                    drive_cell(c);
                    sent++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    idle_cycles($urandom_range(1, 8));
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (trk.pending_flags.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray strobe after the last expected word
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("checked %0d cells, %0d flagged for removal, over %0d critical stress settings",
                 trk.cells_checked, trk.cells_flagged, settings_used);
        $display("includes boundary equality, zero and full-scale limits, extreme gradients");
        if (trk.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
